@@ rtl/core/midpoint_circle_outline_defines.svh @@
// Assertion macros shared by the circle outline RTL.
`ifndef MIDPOINT_CIRCLE_OUTLINE_DEFINES_SVH
`define MIDPOINT_CIRCLE_OUTLINE_DEFINES_SVH

// Check on every rising edge of clk, ignored while rst is high.
`define MCO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge of clk, reset included.
`define MCO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/mco_pkg.sv @@
package mco_pkg;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_e;

  localparam logic [2:0] LAST_IDX = 3'd7;

  typedef struct packed {
    req_e        req_type;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] radius;
    logic [15:0] colour;
  } item_t;

  // One step's worth of work for the pixel emitter
  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] u;
    logic [15:0] v;
    logic [15:0] colour;
    logic        done;
  } job_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } pixel_t;

  // Eight-way symmetry: octant point (u,v) about the centre, fixed order
  function automatic pixel_t pixel_at(input logic [2:0] k, input job_t j);
    pixel_t p;
    case (k)
      3'd0: begin p.x = j.cx + j.u; p.y = j.cy + j.v; end
      3'd1: begin p.x = j.cx + j.v; p.y = j.cy + j.u; end
      3'd2: begin p.x = j.cx - j.v; p.y = j.cy + j.u; end
      3'd3: begin p.x = j.cx - j.u; p.y = j.cy + j.v; end
      3'd4: begin p.x = j.cx - j.u; p.y = j.cy - j.v; end
      3'd5: begin p.x = j.cx - j.v; p.y = j.cy - j.u; end
      3'd6: begin p.x = j.cx + j.v; p.y = j.cy - j.u; end
      default: begin p.x = j.cx + j.u; p.y = j.cy - j.v; end
    endcase
    return p;
  endfunction

endpackage

@@ rtl/core/mco_step.sv @@
`include "midpoint_circle_outline_defines.svh"

module mco_step
  import mco_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  input  item_t item,
  input  logic  job_ready,
  output logic  consume,
  output logic  job_valid,
  output job_t  job
);

  logic               busy;
  logic [15:0]        centre_col;
  logic [15:0]        centre_row;
  logic [15:0]        radius_held;
  logic [15:0]        colour_held;
  logic signed [17:0] octant_x;
  logic [16:0]        octant_y;
  logic [17:0]        step_dx;
  logic [17:0]        step_dy;
  logic signed [19:0] decision_err;

  logic               active;
  logic               err_le;
  logic [16:0]        y_a;
  logic signed [19:0] err_a;
  logic [17:0]        dy_a;
  logic               err_gt;
  logic signed [17:0] x_b;
  logic [17:0]        dx_b;
  logic signed [19:0] err_b;
  logic               done;

  // Point still inside the first octant
  assign active = !($signed(octant_x) < $signed({1'b0, octant_y}));

  // First test: move up a row
  always_comb begin
    err_le = decision_err <= 20'sd0;
    y_a    = err_le ? octant_y + 17'd1 : octant_y;
    err_a  = err_le ? decision_err + $signed({2'b00, step_dy}) : decision_err;
    dy_a   = err_le ? step_dy + 18'd2 : step_dy;
  end

  // Second test: move in a column
  always_comb begin
    err_gt = err_a > 20'sd0;
    x_b    = err_gt ? octant_x - 18'sd1 : octant_x;
    dx_b   = err_gt ? step_dx + 18'd2 : step_dx;
    err_b  = err_gt ? err_a + $signed({2'b00, dx_b}) - $signed({3'b000, radius_held, 1'b0})
                    : err_a;
    done   = $signed(x_b) < $signed({1'b0, y_a});
  end

  assign job_valid = item_valid && (item.req_type == REQ_STEP) && busy && active;
  assign consume   = item_valid && (!job_valid || job_ready);

  assign job.cx     = centre_col;
  assign job.cy     = centre_row;
  assign job.u      = octant_x[15:0];
  assign job.v      = octant_y[15:0];
  assign job.colour = colour_held;
  assign job.done   = done;

  always_ff @(posedge clk) begin
    if (consume) begin
      if (item.req_type == REQ_START) begin
        centre_col   <= item.center_x;
        centre_row   <= item.center_y;
        radius_held  <= item.radius;
        colour_held  <= item.colour;
        octant_x     <= $signed({2'b00, item.radius}) - 18'sd1;
        octant_y     <= '0;
        step_dx      <= 18'd1;
        step_dy      <= 18'd1;
        decision_err <= 20'sd1 - $signed({3'b000, item.radius, 1'b0});
      end else if (job_valid) begin
        octant_x     <= x_b;
        octant_y     <= y_a;
        step_dx      <= dx_b;
        step_dy      <= dy_a;
        decision_err <= err_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (consume) begin
      if (item.req_type == REQ_START) begin
        busy <= 1'b1;
      end else if (job_valid) begin
        busy <= !done;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  `MCO_ASSERT(a_done_clears_busy, job_valid && job_ready && job.done |=> !busy,
              "busy still set after the final step")

endmodule

@@ rtl/core/mco_emit.sv @@
`include "midpoint_circle_outline_defines.svh"

module mco_emit
  import mco_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_in_valid,
  input  job_t        job_in,
  output logic        job_ready,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  output logic        m_tlast,
  output logic        m_tuser
);

  job_t        job;
  logic        job_valid;
  logic [2:0]  idx;
  logic        out_free;
  logic        load_out;
  logic        job_take;
  pixel_t      pix;

  assign out_free  = !m_tvalid || m_tready;
  assign load_out  = job_valid && out_free;
  assign job_ready = !job_valid || (load_out && (idx == LAST_IDX));
  assign job_take  = job_in_valid && job_ready;
  assign pix       = pixel_at(idx, job);

  always_ff @(posedge clk) begin
    if (job_take) begin
      job <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (job_take) begin
      job_valid <= 1'b1;
      idx       <= '0;
    end else if (load_out) begin
      idx <= idx + 3'd1;
      if (idx == LAST_IDX) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {job.colour, pix.y, pix.x};
      m_tlast <= idx == LAST_IDX;
      m_tuser <= (idx == LAST_IDX) && job.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `MCO_ASSERT(a_done_on_last, m_tvalid && m_tuser |-> m_tlast,
              "completion flag away from the eighth pixel")
  `MCO_ASSERT(a_job_held, load_out && (idx != LAST_IDX) |=> job_valid,
              "step dropped before its eighth pixel")

endmodule

@@ rtl/core/midpoint_circle_outline.sv @@
// Midpoint circle outline rasteriser. A start transaction (tuser = 0) loads
// centre, radius and colour and produces no output. Each step transaction
// (tuser = 1) yields the eight symmetric outline pixels of the current octant
// point, one per output transaction, in a fixed order with duplicates kept;
// tlast marks the eighth pixel and tuser on that pixel flags a finished
// outline. Steps sent while idle, or after the outline is finished, produce
// nothing. A step that yields pixels holds the emitter while all eight pass
// the single pixel output register; start and empty steps do not wait and
// overlap with pixels still streaming out. The next step's decision update
// runs while the previous step's pixels drain, so back-to-back steps keep
// the output busy every cycle tready is high. Coordinates wrap modulo 65536.
module midpoint_circle_outline
  import mco_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // center_x, center_y, radius, colour
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // pixel_x, pixel_y, pixel_colour
  output logic        m_tlast,   // last_of_step
  output logic        m_tuser    // circle_done
);

  item_t in_item;
  logic  in_valid;
  logic  consume;
  logic  job_valid;
  job_t  job;
  logic  job_ready;
  logic  s_take;

  // Input register: free it as soon as the step unit has used its contents
  assign s_tready = !in_valid || consume;
  assign s_take   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (s_take) begin
      in_item.req_type <= req_e'(s_tuser);
      in_item.center_x <= s_tdata[15:0];
      in_item.center_y <= s_tdata[31:16];
      in_item.radius   <= s_tdata[47:32];
      in_item.colour   <= s_tdata[63:48];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_take) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  // Decision variables: advance once per step and hand the octant point on
  mco_step u_step (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_valid),
    .item       (in_item),
    .job_ready  (job_ready),
    .consume    (consume),
    .job_valid  (job_valid),
    .job        (job)
  );

  // Pixel emitter: hold the octant point and stream its eight reflections
  mco_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .job_in_valid (job_valid),
    .job_in       (job),
    .job_ready    (job_ready),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import mco_pkg::*;

  // One expected output pixel
  typedef struct {
    logic [15:0] col;
    logic [15:0] row;
    logic [15:0] ink;
    logic        last;
    logic        done;
  } pixel_rec_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;  // center_x, center_y, radius, colour
  logic        s_tuser  = 1'b0;  // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;  // pixel_x, pixel_y, pixel_colour
  logic        m_tlast;  // last_of_step
  logic        m_tuser;  // circle_done

  midpoint_circle_outline uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("midpoint_circle_outline test failed");
    $finish;
  end

  // Outline tracer state, kept in step with the block
  bit          trace_busy;
  logic [15:0] org_col;
  logic [15:0] org_row;
  logic [15:0] rad_held;
  logic [15:0] ink_held;
  int          oc_col;   // octant column, may dip below zero
  int          oc_row;
  int          inc_col;
  int          inc_row;
  int          decision;

  pixel_rec_t  pixels_due[$];
  int          mismatches;
  int          live_items;   // transactions that the block does not ignore
  int          burst_left;
  bit          hold_off_req;

  function automatic item_t make_req(req_e kind, logic [15:0] cx, logic [15:0] cy,
                                     logic [15:0] r, logic [15:0] c);
    item_t it;
    it.req_type = kind;
    it.center_x = cx;
    it.center_y = cy;
    it.radius   = r;
    it.colour   = c;
    return it;
  endfunction

  function automatic void push_pixel(logic [15:0] col, logic [15:0] row, logic last,
                                     logic done);
    pixel_rec_t p;
    p.col  = col;
    p.row  = row;
    p.ink  = ink_held;
    p.last = last;
    p.done = done;
    pixels_due.push_back(p);
  endfunction

  // Work out what one accepted transaction produces and advance the tracer
  function automatic void trace_outline(item_t it);
    logic [15:0] ux;
    logic [15:0] uy;
    logic        fin;
    if (it.req_type == REQ_START) begin
      org_col    = it.center_x;
      org_row    = it.center_y;
      rad_held   = it.radius;
      ink_held   = it.colour;
      oc_col     = int'(it.radius) - 1;
      oc_row     = 0;
      inc_col    = 1;
      inc_row    = 1;
      decision   = 1 - 2 * int'(it.radius);
      trace_busy = 1'b1;
      live_items++;
      return;
    end
    if (!trace_busy) return;
    live_items++;
    // Outline already finished: drop back to idle silently
    if (oc_col < oc_row) begin
      trace_busy = 1'b0;
      return;
    end
    ux = oc_col[15:0];
    uy = oc_row[15:0];
    if (decision <= 0) begin
      oc_row++;
      decision += inc_row;
      inc_row += 2;
    end
    if (decision > 0) begin
      oc_col--;
      inc_col += 2;
      decision += inc_col - 2 * int'(rad_held);
    end
    fin = (oc_col < oc_row);
    if (fin) trace_busy = 1'b0;
    push_pixel(org_col + ux, org_row + uy, 1'b0, 1'b0);
    push_pixel(org_col + uy, org_row + ux, 1'b0, 1'b0);
    push_pixel(org_col - uy, org_row + ux, 1'b0, 1'b0);
    push_pixel(org_col - ux, org_row + uy, 1'b0, 1'b0);
    push_pixel(org_col - ux, org_row - uy, 1'b0, 1'b0);
    push_pixel(org_col - uy, org_row - ux, 1'b0, 1'b0);
    push_pixel(org_col + uy, org_row - ux, 1'b0, 1'b0);
    push_pixel(org_col + ux, org_row - uy, 1'b1, fin);
  endfunction

  // Offer one transaction; called and returning at a rising edge. The sender
  // runs in bursts, and may idle for a random gap when a burst runs out.
  task automatic offer_req(item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.req_type;
    s_tdata  <= {it.colour, it.radius, it.center_y, it.center_x};
    // Inputs only move at rising edges, so the falling edge sees settled values
    do @(negedge clk); while (!s_tready);
    trace_outline(it);
    @(posedge clk);
    burst_left--;
  endtask

  task automatic offer_step();
    offer_req(make_req(REQ_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom)));
  endtask

  // Step until the tracer says the outline is finished, or cut it short
  task automatic draw_circle(item_t start, int max_steps);
    int n;
    offer_req(start);
    n = 0;
    while (trace_busy && n < max_steps) begin
      offer_step();
      n++;
    end
  endtask

  // Receiver: varying stall patterns, plus a long hold-off on request
  initial begin
    int cyc;
    int stall_left;
    cyc = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        case ((cyc / 256) % 4)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ((cyc % 5) != 0) && ((cyc % 7) != 3);
          default: m_tready <= ($urandom_range(0, 9) < 4);
        endcase
      end
      cyc++;
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each output transaction against the oldest expected pixel
  initial begin
    pixel_rec_t p;
    forever begin
      @(negedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel: x %0d y %0d", m_tdata[15:0], m_tdata[31:16]);
          mismatches++;
        end else begin
          p = pixels_due.pop_front();
          check_field("pixel_x", p.col, m_tdata[15:0]);
          check_field("pixel_y", p.row, m_tdata[31:16]);
          check_field("pixel_colour", p.ink, m_tdata[47:32]);
          check_field("last_of_step", p.last, m_tlast);
          check_field("circle_done", p.done, m_tuser);
        end
      end
    end
  end

  task automatic test_idle_step();
    offer_step();
  endtask

  // Zero radius: the first step finds nothing to draw and returns to idle
  task automatic test_zero_radius();
    draw_circle(make_req(REQ_START, 16'd100, 16'd200, 16'd0, 16'h1234), 1);
    offer_step();
  endtask

  // Radius one about the origin: the only step puts all eight pixels on the origin
  task automatic test_unit_radius_wrap();
    draw_circle(make_req(REQ_START, 16'd0, 16'd0, 16'd1, 16'h00ff), 4);
    offer_step();
  endtask

  task automatic test_extreme_fields();
    draw_circle(make_req(REQ_START, 16'hffff, 16'hffff, 16'd3, 16'hffff), 8);
    offer_step();
  endtask

  // Abandon a huge circle after two steps and load a small one in its place
  task automatic test_restart_while_busy();
    draw_circle(make_req(REQ_START, 16'h0000, 16'h0000, 16'hffff, 16'h0000), 2);
    draw_circle(make_req(REQ_START, 16'h8000, 16'h7fff, 16'd2, 16'haaaa), 8);
    offer_step();
  endtask

  // Hold the receiver off while steps keep coming, so the input stalls
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    draw_circle(make_req(REQ_START, 16'($urandom), 16'($urandom), 16'd12, 16'($urandom)),
                64);
  endtask

  task automatic test_random_circles();
    item_t it;
    int    target;
    int    cut;
    target = live_items + 120;
    while (live_items < target) begin
      if ($urandom_range(0, 9) < 2) begin
        // Noise: any kind, any content
        it = make_req(req_e'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
        offer_req(it);
      end else begin
        it = make_req(REQ_START, 16'($urandom), 16'($urandom),
                      16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 24)),
                      16'($urandom));
        cut = 1000;
        if (it.radius > 64 || $urandom_range(0, 4) == 0) cut = $urandom_range(1, 12);
        draw_circle(it, cut);
        if ($urandom_range(0, 2) == 0) offer_step();
      end
    end
  endtask

  initial begin
    mismatches   = 0;
    live_items   = 0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    trace_busy   = 1'b0;
    org_col = '0; org_row = '0; rad_held = '0; ink_held = '0;
    oc_col = 0; oc_row = 0; inc_col = 0; inc_row = 0; decision = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_step();
    test_zero_radius();
    test_unit_radius_wrap();
    test_extreme_fields();
    test_restart_while_busy();
    test_backpressure();
    test_random_circles();

    s_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (mismatches == 0) begin
      $display("midpoint_circle_outline test passed");
    end else begin
      $display("midpoint_circle_outline test failed");
    end
    $finish;
  end

endmodule
